// File: sv/mfr_pkg.sv
// Shared types, constants and the CRC-8 helper for the Manchester frame receiver.
// Used by the front end, the op queue, the back end and the top level.
package mfr_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CRC_POLY = 8'h07;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_LEVELS_INV  = 2'd2;
	localparam logic [1:0] CFG_HL_ONE      = 2'd3;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hD5;
	localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

	typedef enum logic [2:0] {
		EV_PAYLOAD   = 3'd0,
		EV_GOOD      = 3'd1,
		EV_CRC_BAD   = 3'd2,
		EV_INVALID   = 3'd3,
		EV_SYNC_LOST = 3'd4
	} ev_t;

	// Work handed from the front end to the back end.
	typedef enum logic [2:0] {
		OP_INVALID   = 3'd0,
		OP_SYNC_LOST = 3'd1,
		OP_LENGTH    = 3'd2,
		OP_PAYLOAD   = 3'd3,
		OP_CRC       = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} op_entry_t;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic       levels_inverted;
		logic       high_low_means_one;
	} mfr_cfg_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: sv/manchester_frame_receiver_top.sv
// Top level of the Manchester frame receiver: configuration registers and wiring.
// Depends on mfr_pkg, mfr_front, mfr_queue and mfr_back.
//
// Input channel (in_valid, in_stall): each transaction is either a phase-lock
// event (action = 1) or the two half-bit levels of one bit period. One item is
// taken per cycle; in_stall rises only while the internal op queue is full.
// Output channel (out_valid, out_stall): zero or one result per item, in item
// order. The edge that takes an item writes its op into the four-entry queue;
// from the queue head it moves into the result register, which length ops never
// enter, once the register is free or being read. Items are taken at one per
// cycle while the queue is not full; the bit decode in the front end and the
// CRC byte update in the back end are combinational.
// When the receiver holds out_stall, the result register holds its payload,
// ops pile up in the queue, and in_stall rises once four ops are waiting.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready
// and should be written only while the block is idle.
// Reset returns the framer to acquire, empties the queue and the result
// register, and loads the sync bytes 0xD5 and 0xAA with both level options on.
module manchester_frame_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic       first_half_level,
	input  logic       second_half_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_kind,
	output logic [7:0] data_byte,
	output logic [7:0] computed_crc,
	output logic [7:0] received_crc,
	output logic [7:0] frame_length,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	mfr_pkg::mfr_cfg_t  cfg_q;
	mfr_pkg::op_entry_t push_entry;
	mfr_pkg::op_entry_t head_entry;
	logic               push;
	logic               pop;
	logic               not_empty;
	logic               full;
	logic               take;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign take      = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first         <= mfr_pkg::SYNC_FIRST_RST;
			cfg_q.sync_second        <= mfr_pkg::SYNC_SECOND_RST;
			cfg_q.levels_inverted    <= 1'b1;
			cfg_q.high_low_means_one <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				mfr_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first         <= cfg_data;
				mfr_pkg::CFG_SYNC_SECOND: cfg_q.sync_second        <= cfg_data;
				mfr_pkg::CFG_LEVELS_INV:  cfg_q.levels_inverted    <= cfg_data[0];
				mfr_pkg::CFG_HL_ONE:      cfg_q.high_low_means_one <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	mfr_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.take              (take),
		.action            (action),
		.first_half_level  (first_half_level),
		.second_half_level (second_half_level),
		.cfg               (cfg_q),
		.push              (push),
		.push_entry        (push_entry)
	);

	mfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.not_empty  (not_empty),
		.full       (full)
	);

	mfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_entry   (head_entry),
		.not_empty    (not_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.data_byte    (data_byte),
		.computed_crc (computed_crc),
		.received_crc (received_crc),
		.frame_length (frame_length)
	);

endmodule

// File: sv/mfr_front.sv
// Front end: Manchester decoding, byte assembly and the framing state machine.
// Depends on mfr_pkg; emits at most one op per finished byte or invalid pair.
module mfr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic               action,
	input  logic               first_half_level,
	input  logic               second_half_level,
	input  mfr_pkg::mfr_cfg_t  cfg,
	output logic               push,
	output mfr_pkg::op_entry_t push_entry
);

	typedef enum logic [2:0] {
		PH_ACQUIRE = 3'd0,
		PH_SYNC1   = 3'd1,
		PH_SYNC2   = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CRC     = 3'd5
	} phase_t;

	phase_t     phase_q;
	logic [7:0] shift_q;
	logic [2:0] nbits_q;
	logic [7:0] len_q;
	logic [7:0] count_q;

	logic       f_lvl;
	logic       bit_val;
	logic [7:0] byte_next;
	logic [7:0] count_next;
	logic       pair_item;
	logic       pair_bad;
	logic       byte_done;

	assign f_lvl      = first_half_level ^ cfg.levels_inverted;
	assign bit_val    = f_lvl ^ ~cfg.high_low_means_one ^ cfg.levels_inverted;
	assign byte_next  = {shift_q[6:0], bit_val};
	assign count_next = count_q + 8'd1;
	assign pair_item  = take && !action && (phase_q != PH_ACQUIRE);
	// An equal pair of half-bit levels carries no transition.
	assign pair_bad   = pair_item && (first_half_level == second_half_level);
	assign byte_done  = pair_item && !pair_bad && (nbits_q == 3'd7);

	always_comb begin
		push            = 1'b0;
		push_entry.op   = mfr_pkg::OP_INVALID;
		push_entry.data = byte_next;
		if (pair_bad) begin
			push = 1'b1;
		end else if (byte_done) begin
			case (phase_q)
				PH_SYNC1: begin
					push = 1'b0;
				end
				PH_SYNC2: begin
					push          = (byte_next != cfg.sync_second);
					push_entry.op = mfr_pkg::OP_SYNC_LOST;
				end
				PH_LEN: begin
					push          = 1'b1;
					push_entry.op = mfr_pkg::OP_LENGTH;
				end
				PH_PAYLOAD: begin
					push          = 1'b1;
					push_entry.op = mfr_pkg::OP_PAYLOAD;
				end
				PH_CRC: begin
					push          = 1'b1;
					push_entry.op = mfr_pkg::OP_CRC;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ACQUIRE;
			shift_q <= 8'd0;
			nbits_q <= 3'd0;
			len_q   <= 8'd0;
			count_q <= 8'd0;
		end else if (take) begin
			if (phase_q == PH_ACQUIRE) begin
				if (action) begin
					phase_q <= PH_SYNC1;
				end
			end else if (pair_bad) begin
				shift_q <= 8'd0;
				nbits_q <= 3'd0;
				phase_q <= PH_SYNC1;
			end else if (pair_item) begin
				shift_q <= byte_next;
				nbits_q <= nbits_q + 3'd1;
				if (byte_done) begin
					case (phase_q)
						PH_SYNC1: begin
							if (byte_next == cfg.sync_first) begin
								phase_q <= PH_SYNC2;
							end
						end
						PH_SYNC2: begin
							phase_q <= (byte_next == cfg.sync_second) ? PH_LEN : PH_ACQUIRE;
						end
						PH_LEN: begin
							len_q   <= byte_next;
							count_q <= 8'd0;
							phase_q <= (byte_next == 8'd0) ? PH_CRC : PH_PAYLOAD;
						end
						PH_PAYLOAD: begin
							count_q <= count_next;
							if (count_next >= len_q) begin
								phase_q <= PH_CRC;
							end
						end
						default: begin
							phase_q <= PH_ACQUIRE;
						end
					endcase
				end
			end
		end
	end

endmodule

// File: sv/mfr_queue.sv
// Short FIFO of ops between the front end and the back end.
// Depends on mfr_pkg for the entry type and depth.
module mfr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mfr_pkg::op_entry_t push_entry,
	input  logic               pop,
	output mfr_pkg::op_entry_t head_entry,
	output logic               not_empty,
	output logic               full
);

	mfr_pkg::op_entry_t               mem_q [mfr_pkg::QDEPTH];
	logic [mfr_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [mfr_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [mfr_pkg::QCNT_W-1:0]       cnt_q;

	localparam logic [mfr_pkg::QPTR_W-1:0] PTR_LAST = mfr_pkg::QPTR_W'(mfr_pkg::QDEPTH - 1);
	localparam logic [mfr_pkg::QCNT_W-1:0] CNT_FULL = mfr_pkg::QCNT_W'(mfr_pkg::QDEPTH);

	assign head_entry = mem_q[rd_ptr_q];
	assign not_empty  = (cnt_q != '0);
	assign full       = (cnt_q == CNT_FULL);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("op queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("op queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_FULL)
		else $error("op queue count out of range");

endmodule

// File: sv/mfr_back.sv
// Back end: running CRC, frame length copy and the registered result stage.
// Depends on mfr_pkg; consumes ops from the queue in order.
module mfr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  mfr_pkg::op_entry_t head_entry,
	input  logic               not_empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         event_kind,
	output logic [7:0]         data_byte,
	output logic [7:0]         computed_crc,
	output logic [7:0]         received_crc,
	output logic [7:0]         frame_length
);

	logic         out_valid_q;
	mfr_pkg::ev_t kind_q;
	logic [7:0]   data_q;
	logic [7:0]   calc_q;
	logic [7:0]   recv_q;
	logic [7:0]   flen_q;
	logic [7:0]   crc_q;
	logic [7:0]   len_q;

	logic         emits;

	// A length op updates state only; it may drain even while a result waits.
	assign emits = (head_entry.op != mfr_pkg::OP_LENGTH);
	assign pop   = not_empty && (!emits || !out_valid_q || !out_stall);

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign data_byte    = data_q;
	assign computed_crc = calc_q;
	assign received_crc = recv_q;
	assign frame_length = flen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= mfr_pkg::EV_PAYLOAD;
			data_q      <= 8'd0;
			calc_q      <= 8'd0;
			recv_q      <= 8'd0;
			flen_q      <= 8'd0;
			crc_q       <= 8'd0;
			len_q       <= 8'd0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (emits) begin
					out_valid_q <= 1'b1;
					data_q      <= 8'd0;
					calc_q      <= 8'd0;
					recv_q      <= 8'd0;
					flen_q      <= len_q;
				end
				case (head_entry.op)
					mfr_pkg::OP_INVALID: begin
						kind_q <= mfr_pkg::EV_INVALID;
					end
					mfr_pkg::OP_SYNC_LOST: begin
						kind_q <= mfr_pkg::EV_SYNC_LOST;
					end
					mfr_pkg::OP_LENGTH: begin
						len_q <= head_entry.data;
						crc_q <= 8'd0;
					end
					mfr_pkg::OP_PAYLOAD: begin
						kind_q <= mfr_pkg::EV_PAYLOAD;
						data_q <= head_entry.data;
						crc_q  <= mfr_pkg::crc8_update(crc_q, head_entry.data);
					end
					mfr_pkg::OP_CRC: begin
						kind_q <= (crc_q == head_entry.data) ? mfr_pkg::EV_GOOD
						                                      : mfr_pkg::EV_CRC_BAD;
						calc_q <= crc_q;
						recv_q <= head_entry.data;
					end
					default: begin
						kind_q <= mfr_pkg::EV_INVALID;
					end
				endcase
			end
		end
	end

	a_len_clears_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_entry.op == mfr_pkg::OP_LENGTH) |=> crc_q == 8'd0)
		else $error("CRC not cleared by length byte");
	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == mfr_pkg::EV_PAYLOAD) |-> (calc_q == 8'd0 && recv_q == 8'd0))
		else $error("payload result carries CRC fields");
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == mfr_pkg::EV_INVALID || kind_q == mfr_pkg::EV_SYNC_LOST))
		|-> (data_q == 8'd0 && calc_q == 8'd0 && recv_q == 8'd0))
		else $error("error result carries data");

endmodule
